### hdl/mml_pkg.sv
// Shared types and constants for the memory-map line parser.
// No dependencies; used by the parser top level and its checker.
package mml_pkg;

   typedef enum logic [1:0] {
      KIND_NAME_BYTE = 2'd0,
      KIND_AREA      = 2'd1,
      KIND_MALFORMED = 2'd2,
      KIND_END       = 2'd3
   } kind_type;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_R       = 8'h72;
   localparam logic [7:0] CH_W       = 8'h77;
   localparam logic [7:0] CH_X       = 8'h78;
   localparam logic [7:0] CH_S       = 8'h73;
   localparam logic [7:0] CH_P       = 8'h70;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  name_byte;
      logic [63:0] start_addr;
      logic [63:0] end_addr;
      logic [63:0] area_size;
      logic [63:0] file_offset;
      logic [2:0]  prot_bits;
      logic        is_shared;
      logic        is_anonymous;
      logic [11:0] name_length;
   } rsp_type;

   // Hex digit decode: bit 4 set when the character is a hex digit.
   function automatic logic [4:0] hex_decode(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         r = {1'b1, 4'(ch - 8'h30)};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         r = {1'b1, 4'(ch - 8'h57)};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         r = {1'b1, 4'(ch - 8'h37)};
      end
      return r;
   endfunction

endpackage

### hdl/memory_map_line_parser.sv
// Results are registered; one character per cycle is taken while req_stall is low.
// The per-character parse step is a single pass of state update and 64-bit
// shift-and-add between the parse registers.
// A result register plus one skid register decouple req_ from rsp_ stalls.
// Reset (synchronous, active high): start of a fresh line, all values zero,
// no result pending.
module memory_map_line_parser
   import mml_pkg::*;
#(
   parameter int NAME_CAPACITY = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_name_byte,
   output logic [63:0] rsp_start_addr,
   output logic [63:0] rsp_end_addr,
   output logic [63:0] rsp_area_size,
   output logic [63:0] rsp_file_offset,
   output logic [2:0]  rsp_prot_bits,
   output logic        rsp_is_shared,
   output logic        rsp_is_anonymous,
   output logic [11:0] rsp_name_length
);

   // Name counter never exceeds NAME_CAPACITY-1.
   localparam int CNT_W = (NAME_CAPACITY > 2) ? $clog2(NAME_CAPACITY) : 1;
   localparam logic [CNT_W:0] CAP = (CNT_W + 1)'(NAME_CAPACITY);

   typedef enum logic [3:0] {
      PH_START, PH_END, PH_R, PH_W, PH_X, PH_S, PH_SP, PH_OFF,
      PH_MAJ, PH_MIN, PH_INODE, PH_SPACES, PH_NAME, PH_SKIP
   } phase_type;

   // Parse state
   phase_type        phase_ff, phase_in;
   logic [63:0]      acc_ff, acc_in;
   logic [63:0]      start_ff, start_in;
   logic [63:0]      end_ff, end_in;
   logic [63:0]      offset_ff, offset_in;
   logic [3:0]       flags_ff, flags_in;     // bit3 shared, bits 2:0 xwr
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Output register and skid register
   rsp_type out_ff, skid_ff;
   logic    out_valid_ff, skid_valid_ff;

   // Per-character step results
   rsp_type    res;
   logic       res_valid;
   logic [7:0] ch;
   logic [4:0] hex;
   logic       is_dec;
   logic       go;
   logic       take;

   assign ch     = req_end_of_input ? CH_NUL : req_in_byte;
   assign hex    = hex_decode(ch);
   assign is_dec = (ch >= CH_ZERO) && (ch <= CH_NINE);

   // Skid full is the only reason to hold off the requester.
   assign req_stall = skid_valid_ff;
   assign go        = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;

   always_comb begin
      logic fail_v, emit_v, eol_v, newline_v, name_v, after_v;
      logic [CNT_W:0] cnt_next;

      fail_v    = 1'b0;
      emit_v    = 1'b0;
      eol_v     = 1'b0;
      newline_v = 1'b0;
      name_v    = 1'b0;
      after_v   = 1'b0;
      cnt_next  = {1'b0, cnt_ff} + (CNT_W + 1)'(1);

      phase_in  = phase_ff;
      acc_in    = acc_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      offset_in = offset_ff;
      flags_in  = flags_ff;
      cnt_in    = cnt_ff;
      res       = '0;
      res_valid = 1'b0;

      unique case (phase_ff)
         PH_START: begin
            if (hex[4]) begin
               acc_in = {acc_ff[59:0], hex[3:0]};
            end else if (ch == CH_DASH) begin
               start_in = acc_ff;
               acc_in   = '0;
               phase_in = PH_END;
            end else if (ch == CH_NUL && acc_ff == '0) begin
               eol_v = 1'b1;
            end else begin
               fail_v = 1'b1;
            end
         end
         PH_END: begin
            if (hex[4]) begin
               acc_in = {acc_ff[59:0], hex[3:0]};
            end else if (ch != CH_SPACE || acc_ff < start_ff) begin
               fail_v = 1'b1;
            end else begin
               end_in   = acc_ff;
               acc_in   = '0;
               phase_in = PH_R;
            end
         end
         PH_R: begin
            if (ch == CH_R) flags_in[0] = 1'b1;
            if (ch == CH_R || ch == CH_DASH) phase_in = PH_W;
            else fail_v = 1'b1;
         end
         PH_W: begin
            if (ch == CH_W) flags_in[1] = 1'b1;
            if (ch == CH_W || ch == CH_DASH) phase_in = PH_X;
            else fail_v = 1'b1;
         end
         PH_X: begin
            if (ch == CH_X) flags_in[2] = 1'b1;
            if (ch == CH_X || ch == CH_DASH) phase_in = PH_S;
            else fail_v = 1'b1;
         end
         PH_S: begin
            if (ch == CH_S) flags_in[3] = 1'b1;
            if (ch == CH_S || ch == CH_P) phase_in = PH_SP;
            else fail_v = 1'b1;
         end
         PH_SP: begin
            if (ch == CH_SPACE) begin
               acc_in   = '0;
               phase_in = PH_OFF;
            end else begin
               fail_v = 1'b1;
            end
         end
         PH_OFF: begin
            if (hex[4]) begin
               acc_in = {acc_ff[59:0], hex[3:0]};
            end else if (ch == CH_SPACE) begin
               offset_in = acc_ff;
               acc_in    = '0;
               phase_in  = PH_MAJ;
            end else begin
               fail_v = 1'b1;
            end
         end
         PH_MAJ: begin
            // device numbers are checked for form only
            if (hex[4]) begin
            end else if (ch == CH_COLON) begin
               phase_in = PH_MIN;
            end else begin
               fail_v = 1'b1;
            end
         end
         PH_MIN: begin
            if (hex[4]) begin
            end else if (ch == CH_SPACE) begin
               phase_in = PH_INODE;
            end else begin
               fail_v = 1'b1;
            end
         end
         PH_INODE: begin
            // inode value is dropped, digits only advance the parse
            if (!is_dec) after_v = 1'b1;
         end
         PH_SPACES: after_v = 1'b1;
         PH_NAME: begin
            if (ch == CH_NEWLINE) emit_v = 1'b1;
            else if (ch == CH_NUL) fail_v = 1'b1;
            else name_v = 1'b1;
         end
         PH_SKIP: begin
            if (ch == CH_NEWLINE) newline_v = 1'b1;
            else if (ch == CH_NUL) eol_v = 1'b1;
         end
         default: newline_v = 1'b1;
      endcase

      // Separator after the inode: spaces, then a name, newline or error.
      if (after_v) begin
         phase_in = PH_SPACES;
         if (ch == CH_SPACE) begin
         end else if (ch == CH_SLASH || ch == CH_LBRACK) begin
            name_v = 1'b1;
         end else if (ch == CH_NEWLINE) begin
            emit_v = 1'b1;
         end else begin
            fail_v = 1'b1;
         end
      end

      // Name character: over-long names turn into a malformed line.
      if (name_v) begin
         if (cnt_next >= CAP) begin
            fail_v = 1'b1;
         end else begin
            cnt_in        = cnt_next[CNT_W-1:0];
            phase_in      = PH_NAME;
            res_valid     = 1'b1;
            res.kind      = KIND_NAME_BYTE;
            res.name_byte = ch;
         end
      end

      if (fail_v) begin
         res_valid = 1'b1;
         res.kind  = KIND_MALFORMED;
         if (ch == CH_NUL || ch == CH_NEWLINE) newline_v = 1'b1;
         else phase_in = PH_SKIP;
      end

      if (emit_v) begin
         res_valid        = 1'b1;
         res.kind         = KIND_AREA;
         res.start_addr   = start_ff;
         res.end_addr     = end_ff;
         res.area_size    = end_ff - start_ff;
         res.file_offset  = offset_ff;
         res.prot_bits    = flags_ff[2:0];
         res.is_shared    = flags_ff[3];
         res.is_anonymous = (cnt_ff == '0);
         res.name_length  = 12'(cnt_ff);
         newline_v        = 1'b1;
      end

      if (eol_v) begin
         res_valid = 1'b1;
         res.kind  = KIND_END;
         newline_v = 1'b1;
      end

      if (newline_v) begin
         phase_in = PH_START;
         acc_in   = '0;
         flags_in = '0;
         cnt_in   = '0;
      end
   end

   // Parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         acc_ff    <= '0;
         start_ff  <= '0;
         end_ff    <= '0;
         offset_ff <= '0;
         flags_ff  <= '0;
         cnt_ff    <= '0;
      end else if (go) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         start_ff  <= start_in;
         end_ff    <= end_in;
         offset_ff <= offset_in;
         flags_ff  <= flags_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Result valids: output register refills from skid first, then from the step.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= go && res_valid;
         end
      end else if (go && res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) out_ff <= skid_ff;
         else if (go && res_valid) out_ff <= res;
      end else if (go && res_valid) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_ff.kind;
   assign rsp_name_byte    = out_ff.name_byte;
   assign rsp_start_addr   = out_ff.start_addr;
   assign rsp_end_addr     = out_ff.end_addr;
   assign rsp_area_size    = out_ff.area_size;
   assign rsp_file_offset  = out_ff.file_offset;
   assign rsp_prot_bits    = out_ff.prot_bits;
   assign rsp_is_shared    = out_ff.is_shared;
   assign rsp_is_anonymous = out_ff.is_anonymous;
   assign rsp_name_length  = out_ff.name_length;

endmodule

### hdl/mml_checker.sv
// Port-level checks for the memory-map line parser, bound to the top level.
// Depends on mml_pkg for the result kind codes.
module mml_checker
   import mml_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_result_kind,
   input logic [7:0]  rsp_name_byte,
   input logic [63:0] rsp_start_addr,
   input logic [63:0] rsp_end_addr,
   input logic [63:0] rsp_area_size,
   input logic        rsp_is_anonymous,
   input logic [11:0] rsp_name_length
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_name_byte) && $stable(rsp_start_addr))
      else $error("stalled transaction changed");

   a_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_AREA |->
         rsp_area_size == rsp_end_addr - rsp_start_addr
         && rsp_end_addr >= rsp_start_addr)
      else $error("area record size or ordering wrong");

   a_anon: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_AREA |->
         rsp_is_anonymous == (rsp_name_length == 12'd0))
      else $error("anonymity flag disagrees with name length");

   a_name: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_NAME_BYTE |->
         rsp_name_byte != CH_NUL && rsp_name_byte != CH_NEWLINE)
      else $error("name byte carries a terminator");

endmodule

bind memory_map_line_parser mml_checker u_mml_checker (.*);

### test/tb_memory_map_line_parser.sv
// Self-checking testbench for memory_map_line_parser: directed lines, long names,
// back-pressure and randomized listings under several idle and stall mixes.
// Depends on mml_pkg (hdl/mml_pkg.sv) and the parser RTL; reads no files.
module tb_memory_map_line_parser;
   import mml_pkg::*;

   localparam int NAME_LIMIT     = 4096;
   localparam int WATCHDOG_LIMIT = 4000; // cycles with no transaction on either side

   // Parse position within one listing line, in field order.
   typedef enum logic [3:0] {
      P_START, P_END, P_READ, P_WRITE, P_EXEC, P_SHARE, P_GAP, P_OFFSET,
      P_MAJOR, P_MINOR, P_INODE, P_SPACES, P_NAME, P_SKIP
   } line_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_name_byte;
   logic [63:0] rsp_start_addr;
   logic [63:0] rsp_end_addr;
   logic [63:0] rsp_area_size;
   logic [63:0] rsp_file_offset;
   logic [2:0]  rsp_prot_bits;
   logic        rsp_is_shared;
   logic        rsp_is_anonymous;
   logic [11:0] rsp_name_length;

   // Line-parse state mirrored from the block, reset values as after reset.
   line_phase_type line_phase = P_START;
   logic [63:0] number_acc  = '0;
   logic [63:0] held_start  = '0;
   logic [63:0] held_end    = '0;
   logic [63:0] held_offset = '0;
   logic [3:0]  area_flags  = '0; // bit3 = shared
   logic [12:0] name_count  = '0;

   rsp_type     next_result;
   bit          next_result_valid;
   rsp_type     parser_results_due[$];

   int mismatch_count = 0;
   int chars_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_left      = 0;

   memory_map_line_parser #(.NAME_CAPACITY(NAME_LIMIT)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_name_byte    (rsp_name_byte),
      .rsp_start_addr   (rsp_start_addr),
      .rsp_end_addr     (rsp_end_addr),
      .rsp_area_size    (rsp_area_size),
      .rsp_file_offset  (rsp_file_offset),
      .rsp_prot_bits    (rsp_prot_bits),
      .rsp_is_shared    (rsp_is_shared),
      .rsp_is_anonymous (rsp_is_anonymous),
      .rsp_name_length  (rsp_name_length)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Line-parse predictor
   // ---------------------------------------------------------------------

   function automatic bit hex_value(input logic [7:0] c, output logic [3:0] v);
      v = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = 4'(c - CH_ZERO);
         return 1'b1;
      end
      if (c >= "a" && c <= "f") begin
         v = 4'(c - "a" + 8'd10);
         return 1'b1;
      end
      if (c >= "A" && c <= "F") begin
         v = 4'(c - "A" + 8'd10);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic restart_line();
      line_phase = P_START;
      number_acc = '0;
      area_flags = '0;
      name_count = '0;
   endtask

   // Bad character: report it, then drop the rest of the line unless the bad
   // character already ends the line.
   task automatic reject_line(input logic [7:0] ch);
      next_result_valid = 1'b1;
      next_result.kind  = KIND_MALFORMED;
      if (ch == CH_NUL || ch == CH_NEWLINE) begin
         restart_line();
      end else begin
         line_phase = P_SKIP;
      end
   endtask

   task automatic close_record();
      next_result_valid         = 1'b1;
      next_result.kind          = KIND_AREA;
      next_result.start_addr    = held_start;
      next_result.end_addr      = held_end;
      next_result.area_size     = held_end - held_start;
      next_result.file_offset   = held_offset;
      next_result.prot_bits     = area_flags[2:0];
      next_result.is_shared     = area_flags[3];
      next_result.is_anonymous  = (name_count == 0);
      next_result.name_length   = name_count[11:0];
      restart_line();
   endtask

   // A name never reaches NAME_LIMIT characters; the one that would is refused.
   task automatic take_name_char(input logic [7:0] ch);
      if (int'(name_count) + 1 >= NAME_LIMIT) begin
         reject_line(ch);
      end else begin
         name_count            = name_count + 13'd1;
         line_phase            = P_NAME;
         next_result_valid     = 1'b1;
         next_result.kind      = KIND_NAME_BYTE;
         next_result.name_byte = ch;
      end
   endtask

   task automatic take_flag(input logic [7:0] ch, input logic [7:0] letter,
                            input int flag_pos, input line_phase_type following);
      if (ch == letter) begin
         area_flags[flag_pos] = 1'b1;
      end else if (ch != CH_DASH) begin
         reject_line(ch);
         return;
      end
      line_phase = following;
   endtask

   // One character (or end of input) through the line parser; leaves the
   // result it causes, if any, in next_result.
   task automatic parse_listing_char(input logic [7:0] in_ch, input logic at_end);
      logic [7:0] ch;
      logic [3:0] digit;
      bit         is_hex;
      ch                = at_end ? CH_NUL : in_ch;
      next_result       = '0;
      next_result_valid = 1'b0;
      is_hex            = hex_value(ch, digit);
      case (line_phase)
         P_START: begin
            if (is_hex) begin
               number_acc = {number_acc[59:0], digit};
            end else if (ch == CH_DASH) begin
               held_start = number_acc;
               number_acc = '0;
               line_phase = P_END;
            end else if (ch == CH_NUL && number_acc == 0) begin
               next_result_valid = 1'b1;
               next_result.kind  = KIND_END;
               restart_line();
            end else begin
               reject_line(ch);
            end
         end
         P_END: begin
            if (is_hex) begin
               number_acc = {number_acc[59:0], digit};
            end else if (ch != CH_SPACE || number_acc < held_start) begin
               reject_line(ch);
            end else begin
               held_end   = number_acc;
               number_acc = '0;
               line_phase = P_READ;
            end
         end
         P_READ:  take_flag(ch, CH_R, 0, P_WRITE);
         P_WRITE: take_flag(ch, CH_W, 1, P_EXEC);
         P_EXEC:  take_flag(ch, CH_X, 2, P_SHARE);
         P_SHARE: begin
            if (ch == CH_S) begin
               area_flags[3] = 1'b1;
               line_phase    = P_GAP;
            end else if (ch == CH_P) begin
               line_phase = P_GAP;
            end else begin
               reject_line(ch);
            end
         end
         P_GAP: begin
            if (ch != CH_SPACE) begin
               reject_line(ch);
            end else begin
               number_acc = '0;
               line_phase = P_OFFSET;
            end
         end
         P_OFFSET: begin
            if (is_hex) begin
               number_acc = {number_acc[59:0], digit};
            end else if (ch != CH_SPACE) begin
               reject_line(ch);
            end else begin
               held_offset = number_acc;
               number_acc  = '0;
               line_phase  = P_MAJOR;
            end
         end
         P_MAJOR: begin
            if (is_hex) begin
               number_acc = {number_acc[59:0], digit};
            end else if (ch != CH_COLON) begin
               reject_line(ch);
            end else begin
               number_acc = '0;
               line_phase = P_MINOR;
            end
         end
         P_MINOR: begin
            if (is_hex) begin
               number_acc = {number_acc[59:0], digit};
            end else if (ch != CH_SPACE) begin
               reject_line(ch);
            end else begin
               number_acc = '0;
               line_phase = P_INODE;
            end
         end
         P_INODE, P_SPACES: begin
            // inode digits are checked and folded in, then thrown away
            if (line_phase == P_INODE && ch >= CH_ZERO && ch <= CH_NINE) begin
               number_acc = number_acc * 64'd10 + 64'(ch - CH_ZERO);
            end else begin
               line_phase = P_SPACES;
               if (ch == CH_SLASH || ch == CH_LBRACK) begin
                  take_name_char(ch);
               end else if (ch == CH_NEWLINE) begin
                  close_record();
               end else if (ch != CH_SPACE) begin
                  reject_line(ch);
               end
            end
         end
         P_NAME: begin
            if (ch == CH_NEWLINE) begin
               close_record();
            end else if (ch == CH_NUL) begin
               reject_line(ch);
            end else begin
               take_name_char(ch);
            end
         end
         P_SKIP: begin
            if (ch == CH_NEWLINE) begin
               restart_line();
            end else if (ch == CH_NUL) begin
               next_result_valid = 1'b1;
               next_result.kind  = KIND_END;
               restart_line();
            end
         end
         default: restart_line();
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Scoreboard: results are checked before the same edge's input is
   // predicted, so ordering inside the time step never matters.
   // ---------------------------------------------------------------------

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 100) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (parser_results_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: result transaction of kind %0d with nothing outstanding",
                        $time, rsp_result_kind);
            end else begin
               want = parser_results_due.pop_front();
               check_field("result_kind",  64'(want.kind),      64'(rsp_result_kind));
               check_field("name_byte",    64'(want.name_byte), 64'(rsp_name_byte));
               check_field("start_addr",   want.start_addr,     rsp_start_addr);
               check_field("end_addr",     want.end_addr,       rsp_end_addr);
               check_field("area_size",    want.area_size,      rsp_area_size);
               check_field("file_offset",  want.file_offset,    rsp_file_offset);
               check_field("prot_bits",    64'(want.prot_bits), 64'(rsp_prot_bits));
               check_field("is_shared",    64'(want.is_shared), 64'(rsp_is_shared));
               check_field("is_anonymous", 64'(want.is_anonymous),
                           64'(rsp_is_anonymous));
               check_field("name_length",  64'(want.name_length),
                           64'(rsp_name_length));
            end
         end
         if (req_valid && !req_stall) begin
            parse_listing_char(req_in_byte, req_end_of_input);
            if (next_result_valid) begin
               parser_results_due.push_back(next_result);
            end
         end
      end
   end

   // Receiver: random stall, or a long hold-off counted down here when a
   // test asks for one.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog: a stuck handshake on either side ends the run.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers; all entered and left at a falling edge.
   // ---------------------------------------------------------------------

   // One request transaction, with random idle cycles ahead of it.
   task automatic send_char(input logic [7:0] ch, input logic at_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid   = 1'b0;
         req_in_byte = 8'($urandom);
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_in_byte      = ch;
      req_end_of_input = at_end;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      chars_sent++;
      @(negedge clock);
      req_valid        = 1'b0;
      req_end_of_input = 1'b0;
   endtask

   // End of input; the character that rides along is don't-care.
   task automatic send_end();
      send_char(8'($urandom), 1'b1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], 1'b0);
      end
   endtask

   task automatic wait_all_results();
      while (parser_results_due.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Hex text with mixed case and sometimes a leading zero.
   function automatic string hex_text(input logic [63:0] v);
      string s;
      s = $sformatf("%0h", v);
      if ($urandom_range(3) == 0) begin
         s = {"0", s};
      end
      for (int i = 0; i < s.len(); i++) begin
         if (s[i] >= "a" && s[i] <= "f" && $urandom_range(1) == 1) begin
            s[i] = s[i] - 8'd32;
         end
      end
      return s;
   endfunction

   // A random well-formed line, or one whose end address lies below its start.
   task automatic compose_line(output string s, input bit backwards);
      logic [63:0] first_addr, last_addr, span;
      logic [7:0]  c;
      string       name_text, gap_run, major_text, minor_text, inode_text;
      if (backwards) begin
         first_addr = (rand64() >> $urandom_range(63)) | 64'h1;
         last_addr  = first_addr - 64'h1 - (rand64() % first_addr);
      end else begin
         first_addr = rand64() >> $urandom_range(63);
         case ($urandom_range(2))
            0:       span = '0;
            1:       span = 64'($urandom_range(1, 65535));
            default: span = rand64() >> $urandom_range(63);
         endcase
         last_addr = first_addr + span;
         if (last_addr < first_addr) begin
            last_addr = '1;
         end
      end
      major_text = ($urandom_range(5) == 0) ? "" : hex_text(64'($urandom_range(255)));
      minor_text = ($urandom_range(5) == 0) ? "" : hex_text(64'($urandom_range(255)));
      case ($urandom_range(3))
         0:       inode_text = "";
         1:       inode_text = "0";
         default: inode_text = $sformatf("%0d", rand64() >> $urandom_range(63));
      endcase
      gap_run = "";
      repeat ($urandom_range(0, 5)) begin
         gap_run = {gap_run, " "};
      end
      case ($urandom_range(3))
         0: name_text = "";
         1: name_text = ($urandom_range(1) == 1) ? "[heap]" : "[vdso]";
         default: begin
            name_text = "/";
            repeat ($urandom_range(0, 10)) begin
               c = 8'($urandom_range(1, 255));
               if (c == CH_NEWLINE) begin
                  c = CH_SPACE;
               end
               name_text = {name_text, $sformatf("%c", c)};
            end
         end
      endcase
      s = $sformatf("%s-%s %s%s%s%s %s %s:%s %s%s%s\n",
                    hex_text(first_addr), hex_text(last_addr),
                    ($urandom_range(1) == 1) ? "r" : "-",
                    ($urandom_range(1) == 1) ? "w" : "-",
                    ($urandom_range(1) == 1) ? "x" : "-",
                    ($urandom_range(1) == 1) ? "s" : "p",
                    hex_text(rand64() >> $urandom_range(63)),
                    major_text, minor_text, inode_text, gap_run, name_text);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   task automatic test_well_formed_lines();
      send_text("7f00a000-7f00b000 r-xp 0001f000 08:01 131090   /usr/lib/ld.so\n");
      send_text("55aa0000-55AB1000 rw-p 00000000 00:00 0 \n");  // anonymous
      send_text("7ffd0000-7ffd2000 rwxs 0 fd:0a 77 [stack]\n");
   endtask

   task automatic test_field_extremes();
      send_text("0-FFFFFFFFFFFFFFFF rwxs ffffffffffffffff ff:ff 99999999999999999999999 /\n");
      // hex fields longer than 16 digits wrap; empty device numbers and inode
      send_text("10000000000000001-10000000000000002 ---p 1fffffffffffffffff :  \n");
      // every number empty
      send_text("- ---p  : \n");
   endtask

   task automatic test_end_conditions();
      send_end();                       // end of listing at line start
      send_char(CH_NUL, 1'b0);          // NUL byte acts the same
      send_text("00");                  // digits but still zero
      send_end();
      send_text("5");                   // nonzero value: malformed
      send_end();
      send_text("1000-2000 r");         // end of input mid-line
      send_end();
      send_text("1000-2000 r--p 0 0:0 0 /ab");
      send_char(CH_NUL, 1'b0);          // NUL inside a name
      send_text("1000-2000 q--pxyz");   // dropped line, then end of input
      send_end();
   endtask

   task automatic test_malformed_lines();
      send_text("2-1 r--p 0 0:0 0\n");  // end below start
      send_text("1-2\n");               // newline is the bad character
      send_text("g\n");
      send_text("1-2 r--q\n");
      send_text("1-2 r--p_0 0:0 0\n");
      send_text("1-2 r--p 0g 0:0 0\n");
      send_text("1-2 r--p 0 12;\n");
      send_text("1-2 r--p 0 1:2:\n");
      send_text("1-2 r--p 0 0:0 0 x\n");
      send_text("1-2 r--p 0 0:0 0\n");  // resync check
   endtask

   // Name long enough that its length needs several counter bits.
   task automatic test_long_names();
      string body;
      body = "/";
      repeat (46) begin
         body = {body, $sformatf("%c", $urandom_range(33, 126))};
      end
      send_text({"1-2 r-xp 0 0:0 1 ", body, "\n"});
      wait_all_results();
   endtask

   // Long receiver hold-off while requests keep coming, then a full drain.
   task automatic test_backpressure();
      string s;
      s = "400000-401000 r--p 00000000 08:02 4242 /opt/app/lib/libdemo-long-name.so.1.2.3\n";
      hold_request = 300;
      send_text(s);
      wait_all_results();
   endtask

   task automatic test_random_listing(input int idle_pct, input int stall_pct,
                                      input int budget);
      string s;
      int    pick, pos, stop_at;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at        = chars_sent + budget;
      while (chars_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            compose_line(s, pick >= 75 && pick < 80);
            if (pick >= 70 && pick < 75) begin
               pos    = $urandom_range(s.len() - 1);
               s[pos] = 8'($urandom_range(1, 255));
            end
            if (pick >= 80) begin
               // truncated line ended by end of input or a NUL
               send_text(s.substr(0, $urandom_range(0, s.len() - 2)));
               if ($urandom_range(1) == 1) begin
                  send_end();
               end else begin
                  send_char(CH_NUL, 1'b0);
               end
            end else begin
               send_text(s);
            end
         end else if (pick < 92) begin
            if ($urandom_range(1) == 1) begin
               send_end();
            end else begin
               send_char(CH_NUL, 1'b0);
            end
         end else begin
            repeat ($urandom_range(1, 12)) begin
               send_char(8'($urandom), $urandom_range(15) == 0);
            end
            if ($urandom_range(4) != 0) begin
               send_char(CH_NEWLINE, 1'b0);
            end
         end
      end
      wait_all_results();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_well_formed_lines();
      test_field_extremes();
      test_end_conditions();
      test_malformed_lines();
      test_long_names();
      test_backpressure();

      test_random_listing(0, 0, 40);
      test_random_listing(85, 0, 40);
      test_random_listing(0, 85, 40);
      test_random_listing(32, 32, 40);

      // accept everything so a stray result cannot hide behind a stall
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_all_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
